// File: rtl/hse_pkg.sv
// hse_pkg: shared types and sizes for the heap sort engine
// depends on nothing; imported by hse_cell and heap_sort_engine
package hse_pkg;

    localparam int DEPTH = 64;
    localparam int DATA_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [CNT_W-1:0] t_cnt;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;  // place the new value, shift larger ones right
        logic shift;   // drop cell 0, move every value one place left
    } t_cell_ctrl;

endpackage

// File: rtl/heap_sort_engine.sv
// heap_sort_engine: ascending sorter built from a chain of compare-and-hold cells
// depends on hse_pkg and hse_cell
//
// Usage:
//   The slave channel takes one signed 32-bit value per beat; tlast marks the
//   final value of a set. Each beat is inserted into a chain of DEPTH cells
//   kept in ascending order, one beat per cycle with no stall while loading.
//   Values past DEPTH in one set are dropped and the set is flagged.
//   After the tlast beat the master channel delivers the set smallest first,
//   starting the cycle after that beat, one value per cycle while tready is
//   high; tlast marks the largest value and tuser carries the overflow flag
//   on every beat of the set.
//   The slave side holds tready low while the set drains, so the next set
//   starts the cycle after the last master beat.
//   A receiver stall simply holds the current beat; the chain shifts only on
//   an accepted master beat.
//   Reset empties the chain and clears the overflow flag; cell contents are
//   not cleared, only the fill count marks which cells hold data.
module heap_sort_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  hse_pkg::t_data      i_s_axis_tdata,  // [31:0] value
    input  logic                i_s_axis_tlast,  // last_item
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output hse_pkg::t_data      o_m_axis_tdata,  // [31:0] sorted_value
    output logic                o_m_axis_tlast,  // last_of_run
    output logic                o_m_axis_tuser   // [0] overflow
);
    import hse_pkg::*;

    typedef enum logic {
        S_LOAD,
        S_EMIT
    } t_state;

    t_state     r_state;
    t_cnt       r_count;
    logic       r_ovf;
    t_cell_ctrl ctrl;
    logic       in_fire;
    logic       out_fire;
    logic       full;

    t_data      cell_val [DEPTH];
    logic       cell_gt  [DEPTH];
    logic       cell_vld [DEPTH];

    assign full = (r_count == t_cnt'(DEPTH));
    assign o_s_axis_tready = (r_state == S_LOAD);
    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_state == S_EMIT);
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;

    assign ctrl.insert = in_fire && !full;
    assign ctrl.shift  = out_fire;

    assign o_m_axis_tdata = cell_val[0];
    assign o_m_axis_tlast = (r_count == t_cnt'(1));
    assign o_m_axis_tuser = r_ovf;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign cell_vld[i] = (r_count > t_cnt'(i));

        hse_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_new       (i_s_axis_tdata),
            .i_valid     (cell_vld[i]),
            .i_left_val  ((i == 0) ? i_s_axis_tdata : cell_val[(i == 0) ? 0 : i-1]),
            .i_left_gt   ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i-1]),
            .i_right_val ((i == DEPTH-1) ? cell_val[i] : cell_val[(i == DEPTH-1) ? i : i+1]),
            .o_val       (cell_val[i]),
            .o_gt        (cell_gt[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_fire) begin
                        if (full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + t_cnt'(1);
                        end
                        if (i_s_axis_tlast) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_fire) begin
                        r_count <= r_count - t_cnt'(1);
                        if (o_m_axis_tlast) begin
                            r_state <= S_LOAD;
                            r_ovf   <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // a draining set never runs dry before its tlast beat
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_count != '0))
        else $error("emit with empty chain");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(DEPTH))
        else $error("fill count past depth");

    // values leave in ascending order within a set
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !o_m_axis_tlast) |=>
            (o_m_axis_tvalid && (o_m_axis_tdata >= $past(o_m_axis_tdata))))
        else $error("output out of order");

    a_close_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_s_axis_tlast) |=> o_m_axis_tvalid)
        else $error("set closed but no output");

    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_m_axis_tlast) |=> (r_count == '0 && !r_ovf && o_s_axis_tready))
        else $error("chain not empty after last beat");

endmodule

// File: rtl/hse_cell.sv
// hse_cell: one storage cell of the sorting chain
// depends on hse_pkg; instantiated DEPTH times by heap_sort_engine
module hse_cell (
    input  logic               i_clk,
    input  hse_pkg::t_cell_ctrl i_ctrl,
    input  hse_pkg::t_data     i_new,
    input  logic               i_valid,
    input  hse_pkg::t_data     i_left_val,
    input  logic               i_left_gt,
    input  hse_pkg::t_data     i_right_val,
    output hse_pkg::t_data     o_val,
    output logic               o_gt
);
    import hse_pkg::*;

    t_data r_val;
    t_data n_val;

    // held value is larger than the value being inserted
    assign o_gt = i_valid && (r_val > i_new);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.shift) begin
            n_val = i_right_val;
        end else if (i_ctrl.insert) begin
            if (i_left_gt) begin
                n_val = i_left_val;
            end else if (o_gt || !i_valid) begin
                n_val = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
